>>> sv/sprc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprc_pkg
// Shared types and constants for the source port range check block.
// ----------------------------------------------------------------------------
package sprc_pkg;

  localparam int NUM_TABLES       = 16;
  localparam int RANGES_PER_TABLE = 32;

  localparam int TABLE_IDX_W = 4;
  localparam int SLOT_IDX_W  = 5;
  localparam int PORT_W      = 16;
  localparam int ADDR_IN_W   = 32;
  localparam int PROTO_W     = 8;

  // Row address width of the range memory (one row per table).
  localparam int ROW_ADDR_W = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  // Entry select width within a row.
  localparam int ENTRY_SEL_W = $clog2(RANGES_PER_TABLE);

  localparam logic [PORT_W-1:0]    PORT_MAX   = 16'hFFFF;
  localparam logic [PORT_W-1:0]    PORT_ZERO  = 16'h0000;
  localparam logic [ADDR_IN_W-1:0] ADDR_BCAST = 32'hFFFF_FFFF;
  localparam logic [3:0]           MCAST_NIB  = 4'hE;
  localparam logic [PROTO_W-1:0]   PROTO_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0]   PROTO_UDP  = 8'd17;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_CHECK = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [PORT_W-1:0] lo;
    logic [PORT_W-1:0] hi;
  } entry_t;

  typedef entry_t [RANGES_PER_TABLE-1:0] row_t;

  // Control carried from the read stage to the result stage.
  typedef struct packed {
    logic valid;
    logic write_done;
    logic bypass;
    logic do_check;
  } res_ctrl_t;

endpackage

>>> sv/sprc_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprc_row_mem
// Range table store: one row per table, synchronous read, per-row valid bits.
// ----------------------------------------------------------------------------
module sprc_row_mem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [sprc_pkg::ROW_ADDR_W-1:0]  rd_addr_i,
  output sprc_pkg::row_t                   rd_row_o,
  input  logic                             wr_en_i,
  input  logic [sprc_pkg::ROW_ADDR_W-1:0]  wr_addr_i,
  input  sprc_pkg::row_t                   wr_row_i
);

  sprc_pkg::row_t                       mem_q [sprc_pkg::NUM_TABLES];
  sprc_pkg::row_t                       rdata_q;
  logic [sprc_pkg::NUM_TABLES-1:0]      row_valid_q;
  logic                                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Unwritten rows read as all zero (empty entries).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rvalid_q ? rdata_q : '0;

endmodule

>>> sv/sprc_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprc_match
// Parallel port compare against one row; registered per-entry hit vector.
// ----------------------------------------------------------------------------
module sprc_match (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  sprc_pkg::row_t                row_i,
  input  logic [sprc_pkg::PORT_W-1:0]   port_i,
  output logic                          any_hit_o
);

  logic [sprc_pkg::RANGES_PER_TABLE-1:0] hit_d;
  logic [sprc_pkg::RANGES_PER_TABLE-1:0] hit_q;

  always_comb begin
    for (int i = 0; i < sprc_pkg::RANGES_PER_TABLE; i++) begin
      if (row_i[i].lo == sprc_pkg::PORT_ZERO) begin
        hit_d[i] = 1'b0;
      end else if (port_i == sprc_pkg::PORT_MAX) begin
        // top port: high bound cannot express it, low bound must equal it
        hit_d[i] = (row_i[i].lo == sprc_pkg::PORT_MAX);
      end else begin
        hit_d[i] = (row_i[i].lo <= port_i) && (port_i < row_i[i].hi);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign any_hit_o = |hit_q;

endmodule

>>> sv/source_port_range_check_top.sv
`timescale 1ns / 1ps
// The result strobe follows start through the s1_q, s2_q and output registers.
// A new item is not accepted while busy; busy is high for the read-modify-write
//   cycle of the single range memory port pair (read, then compare/write back).
// The receiver cannot stall: result_valid_o is a one-cycle strobe.
// Reset (rst_ni low, async): pipeline empties, all range tables read as empty.
// ----------------------------------------------------------------------------
// source_port_range_check_top
// Per-packet source port range filter with writable range tables.
// ----------------------------------------------------------------------------
module source_port_range_check_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type_i,
  input  logic [sprc_pkg::TABLE_IDX_W-1:0]    table_index_i,
  input  logic [sprc_pkg::SLOT_IDX_W-1:0]     slot_i,
  input  logic [sprc_pkg::PORT_W-1:0]         range_low_i,
  input  logic [sprc_pkg::PORT_W-1:0]         range_high_i,
  input  logic                                is_range_table_i,
  input  logic [sprc_pkg::ADDR_IN_W-1:0]      src_addr_i,
  input  logic [sprc_pkg::PROTO_W-1:0]        protocol_i,
  input  logic [sprc_pkg::PORT_W-1:0]         dst_port_i,
  output logic                                result_valid_o,
  output logic                                verdict_o,
  output logic                                bypassed_o,
  output logic                                write_done_o
);

  // --------------------------------------------------------------------------
  // Request decode at the start transfer
  // --------------------------------------------------------------------------
  logic accept;
  logic is_write;
  logic tbl_ok;
  logic slot_ok;
  logic mcast;
  logic bcast;
  logic other_proto;
  logic bypass;
  logic [sprc_pkg::ROW_ADDR_W-1:0] row_addr;

  assign accept      = start && !busy;
  assign is_write    = (sprc_pkg::req_type_e'(req_type_i) == sprc_pkg::REQ_WRITE);
  assign tbl_ok      = 32'(table_index_i) < sprc_pkg::NUM_TABLES;
  assign slot_ok     = 32'(slot_i) < sprc_pkg::RANGES_PER_TABLE;
  assign row_addr    = sprc_pkg::ROW_ADDR_W'(table_index_i);

  // Multicast 224/4, limited broadcast, or non TCP/UDP bypass the check.
  assign mcast       = (src_addr_i[sprc_pkg::ADDR_IN_W-1 -: 4] == sprc_pkg::MCAST_NIB);
  assign bcast       = (src_addr_i == sprc_pkg::ADDR_BCAST);
  assign other_proto = (protocol_i != sprc_pkg::PROTO_TCP) &&
                       (protocol_i != sprc_pkg::PROTO_UDP);
  assign bypass      = mcast || bcast || other_proto;

  // --------------------------------------------------------------------------
  // Stage 1: memory row arrives; writes merge the slot and write back here.
  // --------------------------------------------------------------------------
  sprc_pkg::res_ctrl_t               s1_d;
  sprc_pkg::res_ctrl_t               s1_q;
  logic                              s1_wr_q;
  logic [sprc_pkg::ROW_ADDR_W-1:0]   s1_addr_q;
  logic [sprc_pkg::ENTRY_SEL_W-1:0]  s1_slot_q;
  sprc_pkg::entry_t                  s1_entry_q;
  logic [sprc_pkg::PORT_W-1:0]       s1_port_q;

  // flags are only carried for an accepted transfer, so idle cycles stay clean
  always_comb begin
    s1_d            = '0;
    s1_d.valid      = accept;
    s1_d.write_done = accept && is_write && tbl_ok && slot_ok;
    s1_d.bypass     = accept && !is_write && bypass;
    s1_d.do_check   = accept && !is_write && !bypass && is_range_table_i &&
                      (dst_port_i != sprc_pkg::PORT_ZERO) && tbl_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      s1_wr_q <= 1'b0;
    end else begin
      s1_q    <= s1_d;
      s1_wr_q <= accept && s1_d.write_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q     <= row_addr;
      s1_slot_q     <= sprc_pkg::ENTRY_SEL_W'(slot_i);
      s1_entry_q.lo <= range_low_i;
      s1_entry_q.hi <= range_high_i;
      s1_port_q     <= dst_port_i;
    end
  end

  sprc_pkg::row_t rd_row;
  sprc_pkg::row_t wr_row;

  sprc_row_mem u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (row_addr),
    .rd_row_o  (rd_row),
    .wr_en_i   (s1_wr_q),
    .wr_addr_i (s1_addr_q),
    .wr_row_i  (wr_row)
  );

  // Read-modify-write: replace only the addressed slot of the row.
  always_comb begin
    for (int i = 0; i < sprc_pkg::RANGES_PER_TABLE; i++) begin
      wr_row[i] = (32'(s1_slot_q) == i) ? s1_entry_q : rd_row[i];
    end
  end

  // Per-entry compare, registered into the hit vector.
  logic any_hit;

  sprc_match u_match (
    .clk_i     (clk_i),
    .en_i      (s1_q.valid),
    .row_i     (rd_row),
    .port_i    (s1_port_q),
    .any_hit_o (any_hit)
  );

  // --------------------------------------------------------------------------
  // Stage 2: reduce hits and register the result strobe.
  // --------------------------------------------------------------------------
  sprc_pkg::res_ctrl_t s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
      verdict_o      <= 1'b0;
      bypassed_o     <= 1'b0;
      write_done_o   <= 1'b0;
    end else begin
      result_valid_o <= s2_q.valid;
      verdict_o      <= s2_q.bypass || (s2_q.do_check && any_hit);
      bypassed_o     <= s2_q.bypass;
      write_done_o   <= s2_q.write_done;
    end
  end

  // Only the memory access cycle blocks; the hit reduction overlaps the next read.
  assign busy = s1_q.valid;

`ifndef NO_ASSERTIONS
  // A row write never overlaps a new read of the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_wr_q |-> !accept)
    else $error("row write overlaps a new read");

  // The interlock keeps at most one item in the memory stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_q.valid |=> !s1_q.valid)
    else $error("back-to-back items in memory stage");

  // Every start transfer yields a result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> ##3 result_valid_o)
    else $error("missing result strobe");

  // A write acknowledgment never carries a forward or bypass flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_done_o |-> (!verdict_o && !bypassed_o))
    else $error("write acknowledged with packet verdict");

  // Result flags only appear with the strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_o || bypassed_o || write_done_o) |-> result_valid_o)
    else $error("result flags without strobe");
`endif

endmodule

>>> verif/source_port_range_check_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_port_range_check_top_tb
// Drives range entry writes and packet checks into the port range filter and
// compares every result strobe against a known result or a shadow predictor.
// Includes a short directed table, then a long random run with random gaps.
// ----------------------------------------------------------------------------
module source_port_range_check_top_tb;

  typedef struct {
    sprc_pkg::req_type_e                  kind;
    logic [sprc_pkg::TABLE_IDX_W-1:0]     tbl;
    logic [sprc_pkg::SLOT_IDX_W-1:0]      slot;
    logic [sprc_pkg::PORT_W-1:0]          lo;
    logic [sprc_pkg::PORT_W-1:0]          hi;
    logic                                 rt;
    logic [sprc_pkg::ADDR_IN_W-1:0]       src;
    logic [sprc_pkg::PROTO_W-1:0]         proto;
    logic [sprc_pkg::PORT_W-1:0]          port;
  } filter_req_t;

  typedef struct packed {
    logic verdict;
    logic bypassed;
    logic write_done;
  } filter_res_t;

  typedef struct {
    filter_req_t req;
    logic        typed;
    filter_res_t res;
  } dir_row_t;

  localparam filter_res_t RES_DROP   = '{1'b0, 1'b0, 1'b0};
  localparam filter_res_t RES_BYPASS = '{1'b1, 1'b1, 1'b0};
  localparam filter_res_t RES_STORED = '{1'b0, 1'b0, 1'b1};

  // Directed rows either carry their result or defer to the predictor.
  localparam logic KNOWN   = 1'b1;
  localparam logic PREDICT = 1'b0;

  localparam int RAND_ITEMS   = 1350;
  localparam int MAX_GAP      = 15;
  localparam int GAP_STRETCH  = 40;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 64;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               start;
  logic                               busy;
  logic                               req_type_i;
  logic [sprc_pkg::TABLE_IDX_W-1:0]   table_index_i;
  logic [sprc_pkg::SLOT_IDX_W-1:0]    slot_i;
  logic [sprc_pkg::PORT_W-1:0]        range_low_i;
  logic [sprc_pkg::PORT_W-1:0]        range_high_i;
  logic                               is_range_table_i;
  logic [sprc_pkg::ADDR_IN_W-1:0]     src_addr_i;
  logic [sprc_pkg::PROTO_W-1:0]       protocol_i;
  logic [sprc_pkg::PORT_W-1:0]        dst_port_i;
  logic                               result_valid_o;
  logic                               verdict_o;
  logic                               bypassed_o;
  logic                               write_done_o;

  source_port_range_check_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .table_index_i    (table_index_i),
    .slot_i           (slot_i),
    .range_low_i      (range_low_i),
    .range_high_i     (range_high_i),
    .is_range_table_i (is_range_table_i),
    .src_addr_i       (src_addr_i),
    .protocol_i       (protocol_i),
    .dst_port_i       (dst_port_i),
    .result_valid_o   (result_valid_o),
    .verdict_o        (verdict_o),
    .bypassed_o       (bypassed_o),
    .write_done_o     (write_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the range tables; empty after reset.
  logic [sprc_pkg::PORT_W-1:0] shadow_lo [sprc_pkg::NUM_TABLES][sprc_pkg::RANGES_PER_TABLE]
    = '{default: '0};
  logic [sprc_pkg::PORT_W-1:0] shadow_hi [sprc_pkg::NUM_TABLES][sprc_pkg::RANGES_PER_TABLE]
    = '{default: '0};

  filter_res_t pending_results[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on      = 1'b1;

  function automatic logic port_listed(logic [sprc_pkg::TABLE_IDX_W-1:0] tbl,
                                       logic [sprc_pkg::PORT_W-1:0] port);
    if (int'(tbl) >= sprc_pkg::NUM_TABLES) return 1'b0;
    for (int i = 0; i < sprc_pkg::RANGES_PER_TABLE; i++) begin
      if (shadow_lo[tbl][i] == sprc_pkg::PORT_ZERO) continue;
      if (port == sprc_pkg::PORT_MAX) begin
        // top port only hits an entry that starts at the top port
        if (shadow_lo[tbl][i] == sprc_pkg::PORT_MAX) return 1'b1;
      end else if (shadow_lo[tbl][i] <= port && port < shadow_hi[tbl][i]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Expected outcome of one transfer; writes update the shadow tables.
  function automatic filter_res_t filter_verdict(filter_req_t rq);
    filter_res_t res;
    logic        skip;
    res = RES_DROP;
    if (rq.kind == sprc_pkg::REQ_WRITE) begin
      if (int'(rq.tbl) < sprc_pkg::NUM_TABLES &&
          int'(rq.slot) < sprc_pkg::RANGES_PER_TABLE) begin
        shadow_lo[rq.tbl][rq.slot] = rq.lo;
        shadow_hi[rq.tbl][rq.slot] = rq.hi;
        res.write_done = 1'b1;
      end
      return res;
    end
    skip = (rq.src[sprc_pkg::ADDR_IN_W-1 -: 4] == sprc_pkg::MCAST_NIB) ||
           (rq.src == sprc_pkg::ADDR_BCAST) ||
           (rq.proto != sprc_pkg::PROTO_TCP && rq.proto != sprc_pkg::PROTO_UDP);
    if (skip) return RES_BYPASS;
    if (!rq.rt || rq.port == sprc_pkg::PORT_ZERO) return RES_DROP;
    res.verdict = port_listed(rq.tbl, rq.port);
    return res;
  endfunction

  // Fields a request kind ignores get random junk so they toggle too.
  function automatic filter_req_t mk_write(int unsigned tbl, int unsigned slot,
                                           logic [sprc_pkg::PORT_W-1:0] lo,
                                           logic [sprc_pkg::PORT_W-1:0] hi);
    filter_req_t rq;
    rq.kind  = sprc_pkg::REQ_WRITE;
    rq.tbl   = sprc_pkg::TABLE_IDX_W'(tbl);
    rq.slot  = sprc_pkg::SLOT_IDX_W'(slot);
    rq.lo    = lo;
    rq.hi    = hi;
    rq.rt    = 1'($urandom);
    rq.src   = sprc_pkg::ADDR_IN_W'($urandom);
    rq.proto = sprc_pkg::PROTO_W'($urandom);
    rq.port  = sprc_pkg::PORT_W'($urandom);
    return rq;
  endfunction

  function automatic filter_req_t mk_check(int unsigned tbl, logic rt,
                                           logic [sprc_pkg::ADDR_IN_W-1:0] src,
                                           logic [sprc_pkg::PROTO_W-1:0] proto,
                                           logic [sprc_pkg::PORT_W-1:0] port);
    filter_req_t rq;
    rq.kind  = sprc_pkg::REQ_CHECK;
    rq.tbl   = sprc_pkg::TABLE_IDX_W'(tbl);
    rq.slot  = sprc_pkg::SLOT_IDX_W'($urandom);
    rq.lo    = sprc_pkg::PORT_W'($urandom);
    rq.hi    = sprc_pkg::PORT_W'($urandom);
    rq.rt    = rt;
    rq.src   = src;
    rq.proto = proto;
    rq.port  = port;
    return rq;
  endfunction

  task automatic add_row(filter_req_t rq, logic typed, filter_res_t res);
    dir_row_t row;
    row.req   = rq;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // Mostly well-formed traffic: writes into a few busy tables, checks whose
  // ports sit on or next to stored bounds, with some bypass and junk mixed in.
  function automatic filter_req_t build_random_req();
    int unsigned                      tbl;
    int unsigned                      ent;
    int unsigned                      pick;
    logic [sprc_pkg::PORT_W-1:0]      lo;
    logic [sprc_pkg::PORT_W-1:0]      hi;
    logic [sprc_pkg::PORT_W-1:0]      port;
    logic [sprc_pkg::ADDR_IN_W-1:0]   src;
    logic [sprc_pkg::PROTO_W-1:0]     proto;
    tbl = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                     : $urandom_range(0, sprc_pkg::NUM_TABLES - 1);
    if ($urandom_range(0, 9) < 3) begin
      pick = $urandom_range(0, 19);
      lo   = (pick == 0) ? sprc_pkg::PORT_ZERO :
             (pick == 1) ? sprc_pkg::PORT_MAX : sprc_pkg::PORT_W'($urandom);
      pick = $urandom_range(0, 9);
      hi   = (pick < 6) ? lo + sprc_pkg::PORT_W'($urandom_range(1, 2000)) :
             (pick < 8) ? sprc_pkg::PORT_MAX : sprc_pkg::PORT_W'($urandom);
      return mk_write(tbl, $urandom_range(0, sprc_pkg::RANGES_PER_TABLE - 1), lo, hi);
    end

    ent  = $urandom_range(0, sprc_pkg::RANGES_PER_TABLE - 1);
    lo   = shadow_lo[tbl][ent];
    hi   = shadow_hi[tbl][ent];
    pick = $urandom_range(0, 19);
    if (pick < 2)       port = sprc_pkg::PORT_ZERO;
    else if (pick < 3)  port = sprc_pkg::PORT_MAX;
    else if (pick < 6)  port = sprc_pkg::PORT_W'($urandom);
    else if (pick < 10) port = lo;
    else if (pick < 12) port = lo - 1'b1;
    else if (pick < 15) port = hi - 1'b1;
    else if (pick < 17) port = hi;
    else                port = lo + ((hi - lo) >> 1);

    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      src = {sprc_pkg::MCAST_NIB, (sprc_pkg::ADDR_IN_W - 4)'($urandom)};
    end else if (pick < 11) begin
      src = sprc_pkg::ADDR_BCAST;
    end else begin
      src = sprc_pkg::ADDR_IN_W'($urandom);
      if (src[sprc_pkg::ADDR_IN_W-1 -: 4] == sprc_pkg::MCAST_NIB)
        src[sprc_pkg::ADDR_IN_W-4] = 1'b1;
      if (src == sprc_pkg::ADDR_BCAST) src[0] = 1'b0;
    end

    pick  = $urandom_range(0, 9);
    proto = (pick < 4) ? sprc_pkg::PROTO_TCP :
            (pick < 8) ? sprc_pkg::PROTO_UDP : sprc_pkg::PROTO_W'($urandom);
    return mk_check(tbl, ($urandom_range(0, 9) != 0), src, proto, port);
  endfunction

  // Entered and left at a falling edge. A zero gap keeps start high into the
  // next transfer without dropping it.
  task automatic send_req(filter_req_t rq, logic typed, filter_res_t known);
    int unsigned gap;
    filter_res_t predicted;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i       <= rq.kind;
    table_index_i    <= rq.tbl;
    slot_i           <= rq.slot;
    range_low_i      <= rq.lo;
    range_high_i     <= rq.hi;
    is_range_table_i <= rq.rt;
    src_addr_i       <= rq.src;
    protocol_i       <= rq.proto;
    dst_port_i       <= rq.port;
    start            <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = filter_verdict(rq);
    pending_results.push_back(typed ? known : predicted);
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(string what, logic got, logic want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, got %0b expected %0b", $time, what, got, want);
  endtask

  // Result strobes are one cycle wide; sample at the edge that closes them.
  always @(posedge clk_i) begin : result_check
    filter_res_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1'b1, 1'b0);
      end else begin
        want = pending_results.pop_front();
        if (verdict_o !== want.verdict)
          report_mismatch("verdict", verdict_o, want.verdict);
        if (bypassed_o !== want.bypassed)
          report_mismatch("bypassed", bypassed_o, want.bypassed);
        if (write_done_o !== want.write_done)
          report_mismatch("write_done", write_done_o, want.write_done);
      end
    end
  end

  // Any transfer on either side resets the stall count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    req_type_i       = sprc_pkg::REQ_WRITE;
    table_index_i    = '0;
    slot_i           = '0;
    range_low_i      = '0;
    range_high_i     = '0;
    is_range_table_i = 1'b0;
    src_addr_i       = '0;
    protocol_i       = '0;
    dst_port_i       = '0;

    // tables empty after reset, so nothing matches
    add_row(mk_check(0, 1'b1, 32'h0A00_0001, sprc_pkg::PROTO_TCP, 16'd80), KNOWN, RES_DROP);
    add_row(mk_check(15, 1'b1, 32'h0000_0000, sprc_pkg::PROTO_UDP, sprc_pkg::PORT_MAX),
            KNOWN, RES_DROP);
    // inclusive low, exclusive high
    add_row(mk_write(0, 0, 16'd1000, 16'd2000), KNOWN, RES_STORED);
    add_row(mk_check(0, 1'b1, 32'hC0A8_0101, sprc_pkg::PROTO_TCP, 16'd999),
            PREDICT, RES_DROP);
    add_row(mk_check(0, 1'b1, 32'hC0A8_0101, sprc_pkg::PROTO_TCP, 16'd1000),
            PREDICT, RES_DROP);
    add_row(mk_check(0, 1'b1, 32'hC0A8_0101, sprc_pkg::PROTO_TCP, 16'd1999),
            PREDICT, RES_DROP);
    add_row(mk_check(0, 1'b1, 32'hC0A8_0101, sprc_pkg::PROTO_TCP, 16'd2000),
            PREDICT, RES_DROP);
    // top port: entry low bound at the top port, high bound ignored
    add_row(mk_write(15, 31, sprc_pkg::PORT_MAX, sprc_pkg::PORT_ZERO), KNOWN, RES_STORED);
    add_row(mk_check(15, 1'b1, 32'h7FFF_FFFF, sprc_pkg::PROTO_UDP, sprc_pkg::PORT_MAX),
            PREDICT, RES_DROP);
    // full-width range still misses the top port
    add_row(mk_write(3, 5, 16'd1, sprc_pkg::PORT_MAX), KNOWN, RES_STORED);
    add_row(mk_check(3, 1'b1, 32'h0101_0101, sprc_pkg::PROTO_TCP, sprc_pkg::PORT_MAX),
            PREDICT, RES_DROP);
    add_row(mk_check(3, 1'b1, 32'h0101_0101, sprc_pkg::PROTO_TCP, 16'd1),
            PREDICT, RES_DROP);
    add_row(mk_check(3, 1'b1, 32'h0101_0101, sprc_pkg::PROTO_TCP, 16'hFFFE),
            PREDICT, RES_DROP);
    // port zero and non-range adjacency drop even on a hit
    add_row(mk_check(3, 1'b1, 32'h0101_0101, sprc_pkg::PROTO_TCP, sprc_pkg::PORT_ZERO),
            KNOWN, RES_DROP);
    add_row(mk_check(3, 1'b0, 32'h0101_0101, sprc_pkg::PROTO_UDP, 16'd1), KNOWN, RES_DROP);
    // multicast and broadcast sources skip the check
    add_row(mk_check(0, 1'b0, 32'hE000_0000, sprc_pkg::PROTO_TCP, sprc_pkg::PORT_ZERO),
            KNOWN, RES_BYPASS);
    add_row(mk_check(0, 1'b0, 32'hEFFF_FFFF, sprc_pkg::PROTO_UDP, 16'd5), KNOWN, RES_BYPASS);
    add_row(mk_check(0, 1'b0, sprc_pkg::ADDR_BCAST, sprc_pkg::PROTO_TCP, 16'd5),
            KNOWN, RES_BYPASS);
    add_row(mk_check(3, 1'b1, 32'hF000_0000, sprc_pkg::PROTO_UDP, 16'd1),
            PREDICT, RES_DROP);
    add_row(mk_check(3, 1'b1, 32'hDFFF_FFFF, sprc_pkg::PROTO_UDP, 16'd1),
            PREDICT, RES_DROP);
    // protocols other than TCP/UDP skip the check
    add_row(mk_check(7, 1'b0, 32'h0A0A_0A0A, 8'd0, sprc_pkg::PORT_ZERO), KNOWN, RES_BYPASS);
    add_row(mk_check(7, 1'b0, 32'h0A0A_0A0A, 8'd255, 16'd5), KNOWN, RES_BYPASS);
    // writing a zero low bound empties the entry
    add_row(mk_write(3, 5, sprc_pkg::PORT_ZERO, sprc_pkg::PORT_MAX), KNOWN, RES_STORED);
    add_row(mk_check(3, 1'b1, 32'h0101_0101, sprc_pkg::PROTO_TCP, 16'd1),
            PREDICT, RES_DROP);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % GAP_STRETCH == 0) gaps_on = ($urandom_range(0, 9) < 7);
      send_req(build_random_req(), PREDICT, RES_DROP);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sprc_pkg.sv
sv/sprc_row_mem.sv
sv/sprc_match.sv
sv/source_port_range_check_top.sv
verif/source_port_range_check_top_tb.sv
